// ===== design/qrvs_pkg.sv =====
// qrvs_pkg: shared constants for the quadratic root and vertex solver.
// Result field widths, root count codes and divider lane order; no dependencies.
package qrvs_pkg;

    localparam int DISC_W  = 34;
    localparam int COUNT_W = 2;
    localparam int ROOT_W  = 40;
    localparam int VX_W    = 40;
    localparam int VY_W    = 48;

    typedef logic [COUNT_W-1:0] root_count_t;

    localparam root_count_t CNT_NONE = 2'd0;
    localparam root_count_t CNT_ONE  = 2'd1;
    localparam root_count_t CNT_TWO  = 2'd2;

    // divider lanes
    localparam int NUM_LANES = 4;
    localparam int LANE_R1   = 0;
    localparam int LANE_R2   = 1;
    localparam int LANE_VX   = 2;
    localparam int LANE_VY   = 3;

endpackage

// ===== design/qrvs_div.sv =====
// qrvs_div: pipelined restoring divider, several numerator lanes over one divisor.
// One quotient bit per stage, NW stages; a tag travels alongside. No package use.
module qrvs_div #(
    parameter int LANES = 4,
    parameter int NW    = 48,
    parameter int DVW   = 17,
    parameter int TW    = 41
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [LANES-1:0][NW-1:0]   num,
    input  logic [DVW-1:0]             den,
    input  logic [TW-1:0]              tag,
    output logic                       out_vld,
    output logic [LANES-1:0][NW-1:0]   quo,
    output logic [TW-1:0]              out_tag
);

    logic                             vld_reg [0:NW-1];
    logic [LANES-1:0][NW-1:0]         nq_reg  [0:NW-1];
    logic [LANES-1:0][DVW-1:0]        rem_reg [0:NW-1];
    logic [DVW-1:0]                   den_reg [0:NW-1];
    logic [TW-1:0]                    tag_reg [0:NW-1];

    for (genvar gi = 0; gi < NW; gi++) begin : g_stage
        logic                       vld_cur;
        logic [LANES-1:0][NW-1:0]   nq_cur;
        logic [LANES-1:0][DVW-1:0]  rem_cur;
        logic [DVW-1:0]             den_cur;
        logic [TW-1:0]              tag_cur;
        logic [LANES-1:0][NW-1:0]   nq_next;
        logic [LANES-1:0][DVW-1:0]  rem_next;

        if (gi == 0) begin : g_first
            assign vld_cur = in_vld;
            assign nq_cur  = num;
            assign rem_cur = '0;
            assign den_cur = den;
            assign tag_cur = tag;
        end
        else begin : g_rest
            assign vld_cur = vld_reg[gi-1];
            assign nq_cur  = nq_reg[gi-1];
            assign rem_cur = rem_reg[gi-1];
            assign den_cur = den_reg[gi-1];
            assign tag_cur = tag_reg[gi-1];
        end

        always_comb
        begin
            logic [DVW:0] rsh;
            logic         ge;
            for (int l = 0; l < LANES; l++)
            begin
                rsh = {rem_cur[l], nq_cur[l][NW-1]};
                ge  = (rsh >= {1'b0, den_cur});
                rem_next[l] = ge ? DVW'(rsh - {1'b0, den_cur}) : rsh[DVW-1:0];
                nq_next[l]  = {nq_cur[l][NW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[gi] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[gi] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[gi]  <= nq_next;
                rem_reg[gi] <= rem_next;
                den_reg[gi] <= den_cur;
                tag_reg[gi] <= tag_cur;
            end
        end
    end

    assign out_vld = vld_reg[NW-1];
    assign quo     = nq_reg[NW-1];
    assign out_tag = tag_reg[NW-1];

endmodule

// ===== design/quadratic_root_vertex_solver.sv =====
// quadratic_root_vertex_solver: top level of the quadratic root and vertex solver.
// Depends on qrvs_pkg and qrvs_div.
//
// Use: an input item carries coefficients coeff_a, coeff_b, coeff_c on a
// valid/ready channel (in_valid, in_ready). Each item yields exactly one
// result item on out_valid/out_ready: discriminant, root_count, both roots,
// the vertex and opens_upward. A zero coeff_a is taken as one.
// Throughput: one item per cycle, sustained while out_ready stays high. An
// item passes the products and discriminant registers, then RB square root
// stages (RB = COEFF_WIDTH + FRAC_BITS + 1), the numerator register, NW
// divider stages (NW = 2*COEFF_WIDTH + FRAC_BITS) and the output register.
// The digit-per-stage square root and bit-per-stage divider set the depth.
// Stall: the whole pipeline advances together; while a result waits on the
// output register and out_ready is low, in_ready drops and every stage holds.
// Bubbles inside the pipe hold with it and are not squeezed out; nothing is
// lost or repeated.
// Reset: rst_n clears every stage's valid bit; no result is pending after it.
module quadratic_root_vertex_solver #(
    parameter int COEFF_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COEFF_WIDTH-1:0]       coeff_a,
    input  logic signed [COEFF_WIDTH-1:0]       coeff_b,
    input  logic signed [COEFF_WIDTH-1:0]       coeff_c,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qrvs_pkg::DISC_W-1:0]  discriminant,
    output qrvs_pkg::root_count_t               root_count,
    output logic signed [qrvs_pkg::ROOT_W-1:0]  root_first,
    output logic signed [qrvs_pkg::ROOT_W-1:0]  root_second,
    output logic signed [qrvs_pkg::VX_W-1:0]    vertex_x,
    output logic signed [qrvs_pkg::VY_W-1:0]    vertex_y,
    output logic                                opens_upward
);

    import qrvs_pkg::*;

    localparam int W   = COEFF_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2 * W + 2;            // discriminant, signed
    localparam int RW  = 2 * W + 1 + 2 * F;    // radicand d * 2^2F
    localparam int RWE = RW + (RW % 2);
    localparam int RB  = RWE / 2;              // root bits
    localparam int RMW = RB + 3;               // partial remainder
    localparam int RNW = W + F + 3;            // signed root numerator
    localparam int NW  = 2 * W + F;            // divider numerator magnitude
    localparam int DVW = W + 1;                // divisor magnitude 2|a|
    localparam int QW  = NW + 1;               // signed quotient
    localparam int XW  = (QW > VY_W) ? QW : VY_W;
    localparam int DXW = (DW > DISC_W) ? DW : DISC_W;
    localparam int TW  = DW + COUNT_W + 1 + NUM_LANES;

    // tag layout: {disc, count, up, negative flags}
    localparam int TG_NEG_LO = 0;
    localparam int TG_UP     = NUM_LANES;
    localparam int TG_CNT_LO = NUM_LANES + 1;
    localparam int TG_D_LO   = NUM_LANES + 1 + COUNT_W;

    logic adv;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: products ----------------
    logic                  p1_valid_reg;
    logic signed [2*W-1:0] p1_bb_reg, p1_bb_next;
    logic signed [2*W-1:0] p1_ac_reg, p1_ac_next;
    logic signed [W-1:0]   p1_a_reg, p1_a_next;
    logic signed [W-1:0]   p1_b_reg;

    always_comb
    begin
        p1_a_next  = (coeff_a == '0) ? W'(1) : coeff_a;
        p1_bb_next = coeff_b * coeff_b;
        p1_ac_next = p1_a_next * coeff_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_bb_reg <= p1_bb_next;
            p1_ac_reg <= p1_ac_next;
            p1_a_reg  <= p1_a_next;
            p1_b_reg  <= coeff_b;
        end
    end

    // ---------------- square root pipeline ----------------
    // index 0 is the discriminant stage; stage k holds k root digits
    logic                  sq_valid_reg [0:RB];
    logic [RWE-1:0]        sq_rad_reg   [0:RB];
    logic [RMW-1:0]        sq_rem_reg   [0:RB];
    logic [RB-1:0]         sq_root_reg  [0:RB];
    logic signed [DW-1:0]  sq_d_reg     [0:RB];
    logic signed [W-1:0]   sq_a_reg     [0:RB];
    logic signed [W-1:0]   sq_b_reg     [0:RB];

    logic signed [DW-1:0]  d_next;
    logic [RWE-1:0]        rad_next;

    always_comb
    begin
        d_next   = DW'(p1_bb_reg) - (DW'(p1_ac_reg) <<< 2);
        rad_next = (d_next > 0) ? (RWE'(d_next[DW-2:0]) << (2 * F)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg[0] <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rad_reg[0]  <= rad_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_d_reg[0]    <= d_next;
            sq_a_reg[0]    <= p1_a_reg;
            sq_b_reg[0]    <= p1_b_reg;
        end
    end

    for (genvar k = 0; k < RB; k++) begin : g_sq
        logic [1:0]     pair;
        logic [RMW-1:0] rsh;
        logic [RMW-1:0] trial;
        logic           ge;
        logic [RMW-1:0] rem_next;
        logic [RB-1:0]  root_next;

        always_comb
        begin
            pair      = sq_rad_reg[k][RWE-1-2*k -: 2];
            rsh       = {sq_rem_reg[k][RMW-3:0], pair};
            trial     = RMW'({sq_root_reg[k], 2'b01});
            ge        = (rsh >= trial);
            rem_next  = ge ? (rsh - trial) : rsh;
            root_next = {sq_root_reg[k][RB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rad_reg[k+1]  <= sq_rad_reg[k];
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
                sq_d_reg[k+1]    <= sq_d_reg[k];
                sq_a_reg[k+1]    <= sq_a_reg[k];
                sq_b_reg[k+1]    <= sq_b_reg[k];
            end
        end
    end

    // ---------------- numerator preparation ----------------
    logic                           pr_valid_reg;
    logic [NUM_LANES-1:0][NW-1:0]   pr_num_reg, pr_num_next;
    logic [DVW-1:0]                 pr_den_reg, pr_den_next;
    logic [TW-1:0]                  pr_tag_reg, pr_tag_next;

    always_comb
    begin
        logic signed [RNW-1:0] negb_fx;
        logic signed [RNW-1:0] s_v;
        logic signed [RNW-1:0] n1;
        logic signed [RNW-1:0] n2;
        logic signed [DW-1:0]  d_v;
        logic signed [DW-1:0]  d_abs;
        logic signed [W:0]     a_abs;
        logic                  a_neg;
        logic [NUM_LANES-1:0]  neg;
        root_count_t           cnt;

        d_v     = sq_d_reg[RB];
        a_neg   = sq_a_reg[RB][W-1];
        negb_fx = (-RNW'(sq_b_reg[RB])) <<< F;
        s_v     = RNW'(sq_root_reg[RB]);
        n1      = negb_fx + s_v;
        n2      = negb_fx - s_v;
        d_abs   = (d_v < 0) ? -d_v : d_v;
        a_abs   = a_neg ? -(W+1)'(sq_a_reg[RB]) : (W+1)'(sq_a_reg[RB]);

        pr_num_next[LANE_R1] = NW'((n1 < 0) ? -n1 : n1);
        pr_num_next[LANE_R2] = NW'((n2 < 0) ? -n2 : n2);
        pr_num_next[LANE_VX] = NW'((negb_fx < 0) ? -negb_fx : negb_fx);
        pr_num_next[LANE_VY] = NW'(d_abs) << (F - 1);
        pr_den_next          = {a_abs[W-1:0], 1'b0};

        neg[LANE_R1] = (n1 < 0) ^ a_neg;
        neg[LANE_R2] = (n2 < 0) ^ a_neg;
        neg[LANE_VX] = (negb_fx < 0) ^ a_neg;
        neg[LANE_VY] = (d_v > 0) ^ a_neg;

        priority if (d_v > 0)
            cnt = CNT_TWO;
        else if (d_v == 0)
            cnt = CNT_ONE;
        else
            cnt = CNT_NONE;

        pr_tag_next = {d_v, cnt, !a_neg, neg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pr_valid_reg <= sq_valid_reg[RB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_num_reg <= pr_num_next;
            pr_den_reg <= pr_den_next;
            pr_tag_reg <= pr_tag_next;
        end
    end

    // ---------------- division ----------------
    logic                           dv_valid;
    logic [NUM_LANES-1:0][NW-1:0]   dv_quo;
    logic [TW-1:0]                  dv_tag;

    qrvs_div #(
        .LANES (NUM_LANES),
        .NW    (NW),
        .DVW   (DVW),
        .TW    (TW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (pr_valid_reg),
        .num     (pr_num_reg),
        .den     (pr_den_reg),
        .tag     (pr_tag_reg),
        .out_vld (dv_valid),
        .quo     (dv_quo),
        .out_tag (dv_tag)
    );

    // ---------------- sign fix-up and output register ----------------
    logic                        out_valid_reg;
    logic signed [DISC_W-1:0]    disc_reg, disc_next;
    root_count_t                 cnt_reg, cnt_next;
    logic signed [ROOT_W-1:0]    r1_reg, r1_next;
    logic signed [ROOT_W-1:0]    r2_reg, r2_next;
    logic signed [VX_W-1:0]      vx_reg, vx_next;
    logic signed [VY_W-1:0]      vy_reg, vy_next;
    logic                        up_reg, up_next;

    always_comb
    begin
        logic signed [QW-1:0] q [NUM_LANES];
        logic signed [XW-1:0] qx [NUM_LANES];
        logic signed [DW-1:0] d_t;

        for (int l = 0; l < NUM_LANES; l++)
        begin
            q[l]  = dv_tag[TG_NEG_LO + l] ? -QW'(dv_quo[l]) : QW'(dv_quo[l]);
            qx[l] = XW'(q[l]);
        end

        d_t       = dv_tag[TG_D_LO +: DW];
        disc_next = DISC_W'(DXW'(d_t));
        cnt_next  = dv_tag[TG_CNT_LO +: COUNT_W];
        up_next   = dv_tag[TG_UP];
        vx_next   = qx[LANE_VX][VX_W-1:0];
        vy_next   = qx[LANE_VY][VY_W-1:0];
        if (cnt_next == CNT_NONE)
        begin
            r1_next = '0;
            r2_next = '0;
        end
        else
        begin
            r1_next = qx[LANE_R1][ROOT_W-1:0];
            r2_next = qx[LANE_R2][ROOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            disc_reg <= disc_next;
            cnt_reg  <= cnt_next;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
            up_reg   <= up_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign discriminant = disc_reg;
    assign root_count   = cnt_reg;
    assign root_first   = r1_reg;
    assign root_second  = r2_reg;
    assign vertex_x     = vx_reg;
    assign vertex_y     = vy_reg;
    assign opens_upward = up_reg;

`ifndef NO_ASSERTIONS
    // a double root is the vertex
    a_one_root: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_count == CNT_ONE) |->
            (root_first == root_second && root_first == vertex_x))
        else $error("double root differs from vertex");

    // no real roots gives zero roots
    a_no_root: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_count == CNT_NONE) |->
            (root_first == '0 && root_second == '0))
        else $error("roots not zero without real roots");

    // a stalled output stops intake
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output stalled");
`endif

endmodule
